// ===== hdl/single_wire_sensor_edge_decoder_top_macros.svh =====
// Assertion helpers used by the checker.
`ifndef SINGLE_WIRE_SENSOR_EDGE_DECODER_TOP_MACROS_SVH
`define SINGLE_WIRE_SENSOR_EDGE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SWSED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SWSED_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/swsed_pkg.sv =====
package swsed_pkg;

  typedef enum logic [1:0] {
    CMD_EDGE    = 2'd0,
    CMD_BEGIN   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_CONSUME = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_HOST_LOW  = 4'd1,
    PH_HOST_HIGH = 4'd2,
    PH_WAIT_LOW  = 4'd3,
    PH_WAIT_HIGH = 4'd4,
    PH_BIT_LOW   = 4'd5,
    PH_BIT_HIGH  = 4'd6,
    PH_DONE      = 4'd7,
    PH_ERROR     = 4'd8
  } phase_t;

  localparam int TS_W        = 32;
  localparam int READING_W   = 40;
  localparam int SERIAL_W    = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;

  // pulse windows in microseconds
  localparam logic [TS_W-1:0] RESP_LO    = 32'd70;
  localparam logic [TS_W-1:0] RESP_HI    = 32'd90;
  localparam logic [TS_W-1:0] BITLOW_LO  = 32'd45;
  localparam logic [TS_W-1:0] BITLOW_HI  = 32'd80;
  localparam logic [TS_W-1:0] ZERO_MIN   = 32'd20;
  localparam logic [TS_W-1:0] ZERO_MAX   = 32'd30;
  localparam logic [TS_W-1:0] ONE_LO     = 32'd65;
  localparam logic [TS_W-1:0] ONE_HI     = 32'd80;
  localparam logic [7:0]      BYTE_MASK  = 8'hFF;

  typedef struct packed {
    cmd_t            command;
    logic [TS_W-1:0] timestamp_us;
    logic            line_level;
  } evt_t;

  // first field in the highest bits
  typedef struct packed {
    logic                 checksum_ok;
    logic [SERIAL_W-1:0]  reading_serial;
    logic [READING_W-1:0] reading;
    logic                 reading_ready;
    phase_t               phase;
    logic                 status;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

// ===== hdl/swsed_core.sv =====
module swsed_core
  import swsed_pkg::*;
#(
  parameter int FRAME_BITS = 40
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  evt_t evt,
  output res_t res,
  output logic frame_done
);

  localparam int BC_W  = $clog2(FRAME_BITS + 1);
  localparam int IDX_W = $clog2(FRAME_BITS);

  phase_t                phase_r, phase_nxt;
  logic [TS_W-1:0]       last_r, last_nxt;
  logic [BC_W-1:0]       bit_count_r, bit_count_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  ready_r, ready_nxt;
  logic [SERIAL_W-1:0]   counter_r, counter_nxt;
  logic [SERIAL_W-1:0]   serial_r, serial_nxt;

  logic [TS_W-1:0]       elapsed;
  logic [BC_W-1:0]       bit_count_inc;
  logic [IDX_W-1:0]      bit_idx;
  logic                  is_zero;
  logic                  is_one;
  logic [63:0]           frame_ext;
  logic [READING_W-1:0]  rd;
  logic [9:0]            sum;

  assign elapsed       = evt.timestamp_us - last_r;
  assign bit_count_inc = bit_count_r + BC_W'(1);
  assign bit_idx       = IDX_W'(FRAME_BITS - 1) - bit_count_r[IDX_W-1:0];
  assign is_zero       = (elapsed >= ZERO_MIN) && (elapsed <= ZERO_MAX);
  assign is_one        = (elapsed > ONE_LO) && (elapsed < ONE_HI);

  always_comb begin
    phase_nxt     = phase_r;
    last_nxt      = last_r;
    bit_count_nxt = bit_count_r;
    frame_nxt     = frame_r;
    ready_nxt     = ready_r;
    counter_nxt   = counter_r;
    serial_nxt    = serial_r;
    frame_done    = 1'b0;
    unique case (evt.command)
      CMD_EDGE: begin
        last_nxt = evt.timestamp_us;
        unique case (phase_r)
          PH_WAIT_LOW: begin
            phase_nxt = evt.line_level ? PH_WAIT_HIGH : PH_ERROR;
          end
          PH_WAIT_HIGH: begin
            phase_nxt = (!evt.line_level && elapsed > RESP_LO && elapsed < RESP_HI)
                        ? PH_BIT_LOW : PH_ERROR;
          end
          PH_BIT_LOW: begin
            phase_nxt = (evt.line_level && elapsed > BITLOW_LO && elapsed < BITLOW_HI)
                        ? PH_BIT_HIGH : PH_ERROR;
          end
          PH_BIT_HIGH: begin
            if (evt.line_level || !(is_zero || is_one)) begin
              phase_nxt = PH_ERROR;
            end else begin
              if (!is_zero) begin
                frame_nxt[bit_idx] = 1'b1;
              end
              bit_count_nxt = bit_count_inc;
              if (bit_count_inc == BC_W'(FRAME_BITS)) begin
                phase_nxt   = PH_DONE;
                serial_nxt  = counter_r;
                counter_nxt = counter_r + SERIAL_W'(1);
                ready_nxt   = 1'b1;
                frame_done  = 1'b1;
              end else begin
                phase_nxt = PH_BIT_LOW;
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
      CMD_BEGIN: begin
        phase_nxt     = PH_HOST_LOW;
        bit_count_nxt = '0;
        frame_nxt     = '0;
      end
      CMD_RELEASE: begin
        if (phase_r == PH_HOST_LOW) begin
          last_nxt  = evt.timestamp_us;
          phase_nxt = PH_WAIT_LOW;
        end
      end
      CMD_CONSUME: begin
        ready_nxt = 1'b0;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  assign frame_ext = 64'(frame_nxt);
  assign rd        = frame_ext[READING_W-1:0];
  assign sum       = 10'(rd[39:32]) + 10'(rd[31:24]) + 10'(rd[23:16]) + 10'(rd[15:8]);

  always_comb begin
    res.status         = (phase_nxt == PH_ERROR);
    res.phase          = phase_nxt;
    res.reading_ready  = ready_nxt;
    res.reading        = rd;
    res.reading_serial = serial_nxt;
    res.checksum_ok    = ((sum[7:0] & BYTE_MASK) == rd[7:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      last_r      <= '0;
      bit_count_r <= '0;
      frame_r     <= '0;
      ready_r     <= 1'b0;
      counter_r   <= '0;
      serial_r    <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      bit_count_r <= bit_count_nxt;
      frame_r     <= frame_nxt;
      ready_r     <= ready_nxt;
      counter_r   <= counter_nxt;
      serial_r    <= serial_nxt;
    end
  end

endmodule

// ===== hdl/single_wire_sensor_edge_decoder_top.sv =====
// Single-wire sensor edge decoder.
// Input stream: one word per host event. in_tuser carries the command (edge,
// begin, release, consume); in_tdata carries the event time and the line
// level after the edge. Every accepted word yields exactly one result word.
// Output stream: out_tdata carries status, phase, ready flag, the current
// frame bytes, the serial of the last completed frame and the checksum flag;
// out_tlast is high on the word whose edge completed the last frame bit.
// An accepted word is first registered in the input stage, then decoded into
// the output queue, whose head is shown on the output.
// Throughput: one word per cycle while the output queue has room, set by the
// single decode step between the input register and the two-entry output queue.
// Reset (rst_n low, synchronous) returns the decoder to idle with cleared
// time, frame, ready flag and serials, and empties both stages.
// When the receiver stalls, results collect in the output queue; once it
// holds two words, the decode step holds and in_tready drops.
module single_wire_sensor_edge_decoder_top
  import swsed_pkg::*;
#(
  parameter int FRAME_BITS = 40
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // timestamp_us[31:0], line_level[32]
  input  logic [1:0]             in_tuser,   // command[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status[0], phase[4:1], reading_ready[5],
                                             // reading[45:6], reading_serial[61:46],
                                             // checksum_ok[62]
  output logic                   out_tlast   // frame_done
);

  logic s0_valid_r, s0_valid_nxt;
  evt_t s0_evt_r;

  logic q0_valid_r, q0_valid_nxt;
  logic q1_valid_r, q1_valid_nxt;
  res_t q0_res_r, q0_res_nxt;
  res_t q1_res_r, q1_res_nxt;
  logic q0_last_r, q0_last_nxt;
  logic q1_last_r, q1_last_nxt;

  logic fire;
  logic pop;
  logic in_fire;
  res_t core_res;
  logic core_done;

  assign fire      = s0_valid_r && !q1_valid_r;
  assign pop       = q0_valid_r && out_tready;
  assign in_tready = !s0_valid_r || fire;
  assign in_fire   = in_tvalid && in_tready;

  swsed_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (fire),
    .evt        (s0_evt_r),
    .res        (core_res),
    .frame_done (core_done)
  );

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_fire) begin
      s0_valid_nxt = 1'b1;
    end else if (fire) begin
      s0_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_evt_r.command      <= cmd_t'(in_tuser);
      s0_evt_r.timestamp_us <= in_tdata[TS_W-1:0];
      s0_evt_r.line_level   <= in_tdata[TS_W];
    end
  end

  // two-entry output queue, head in q0
  always_comb begin
    q0_valid_nxt = q0_valid_r;
    q1_valid_nxt = q1_valid_r;
    q0_res_nxt   = q0_res_r;
    q1_res_nxt   = q1_res_r;
    q0_last_nxt  = q0_last_r;
    q1_last_nxt  = q1_last_r;
    priority if (pop && !fire) begin
      q0_valid_nxt = q1_valid_r;
      q0_res_nxt   = q1_res_r;
      q0_last_nxt  = q1_last_r;
      q1_valid_nxt = 1'b0;
    end else if (fire && !pop) begin
      if (!q0_valid_r) begin
        q0_valid_nxt = 1'b1;
        q0_res_nxt   = core_res;
        q0_last_nxt  = core_done;
      end else begin
        q1_valid_nxt = 1'b1;
        q1_res_nxt   = core_res;
        q1_last_nxt  = core_done;
      end
    end else if (fire && pop) begin
      if (q1_valid_r) begin
        q0_res_nxt  = q1_res_r;
        q0_last_nxt = q1_last_r;
        q1_res_nxt  = core_res;
        q1_last_nxt = core_done;
      end else begin
        q0_res_nxt  = core_res;
        q0_last_nxt = core_done;
      end
    end else begin
      q0_valid_nxt = q0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_valid_r <= 1'b0;
      q1_valid_r <= 1'b0;
    end else begin
      q0_valid_r <= q0_valid_nxt;
      q1_valid_r <= q1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_res_r  <= q0_res_nxt;
    q1_res_r  <= q1_res_nxt;
    q0_last_r <= q0_last_nxt;
    q1_last_r <= q1_last_nxt;
  end

  assign out_tvalid = q0_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, q0_res_r};
  assign out_tlast  = q0_last_r;

endmodule

// ===== hdl/swsed_checker.sv =====
`include "single_wire_sensor_edge_decoder_top_macros.svh"

module swsed_checker
  import swsed_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  res_t r;

  assign r = out_tdata[RES_W-1:0];

  `SWSED_ASSERT_IMP(a_status_phase, out_tvalid, r.status == (r.phase == PH_ERROR), "status disagrees with phase")
  `SWSED_ASSERT_IMP(a_last_done, out_tvalid && out_tlast, r.phase == PH_DONE && r.reading_ready, "frame end without done and ready")
  `SWSED_ASSERT_IMP(a_host_low_clear, out_tvalid && r.phase == PH_HOST_LOW, r.reading == '0 && !out_tlast, "frame not cleared in host low")
  `SWSED_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled word changed")

endmodule

bind single_wire_sensor_edge_decoder_top swsed_checker u_swsed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
